FILE: rtl/deq_bd_pkg.sv
package deq_bd_pkg;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_DROP_FRONT = 3'd2;
    localparam logic [2:0] MODE_DROP_BACK  = 3'd3;
    localparam logic [2:0] MODE_DUMP       = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] push_value;
        logic [6:0]         drop_count;
    } t_in;

    typedef struct packed {
        logic signed [31:0] element_value;
        logic               is_element;
        logic               is_last;
        logic [6:0]         fill_level;
        logic               push_rejected;
    } t_out;

endpackage

FILE: rtl/double_ended_queue_bulk_drop.sv
// Bounded double-ended queue of signed words in a ring buffer.
// Input channel (i_in_valid / o_in_ready, i_in_data): one beat is one
// operation: push front, push back, drop front, drop back, or dump.
// Output channel (o_out_valid / i_out_ready, o_out_data): push, drop and
// unused modes give one status beat with the new fill level; a push into a
// full queue is ignored and flagged. A dump gives one beat per stored word,
// front to back, the last one marked; an empty dump gives one status beat.
// Timing: the status beat of a push, drop or status operation is valid the
// cycle after acceptance. A dump reads each word in a memory read state,
// set by the single registered read port of the word store, then loads it in
// an output load state that waits for a free output register. Input is ready
// only while no dump is running and the output register is empty or being drained.
// Reset (synchronous, active low) empties the queue and the output register;
// the word store itself is not cleared, stale entries are never read.
// A stalled receiver holds the output beat and the block waits; no beat is
// lost or repeated.
module double_ended_queue_bulk_drop
    import deq_bd_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = PW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
        if (s >= SW'(DEPTH)) begin
            return PW'(s - SW'(DEPTH));
        end
        return PW'(s);
    endfunction

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rd_data;

    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic                  w_out_free;
    logic                  w_in_acc;
    logic                  w_full;
    logic [CW-1:0]         w_drop_n;
    logic                  w_wr_en;
    logic [PW-1:0]         w_wr_addr;
    logic [WORD_WIDTH-1:0] w_wr_data;
    logic [PW-1:0]         w_rd_addr;
    logic                  w_dump_last;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_full      = (r_fill == CW'(DEPTH));
    assign w_drop_n    = (i_in_data.drop_count > 7'(r_fill)) ? r_fill
                                                             : CW'(i_in_data.drop_count);
    assign w_wr_data   = WORD_WIDTH'(i_in_data.push_value);
    assign w_rd_addr   = wrap(SW'(r_front) + SW'(r_idx));
    assign w_dump_last = ((r_idx + CW'(1)) == r_fill);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_front;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid         = 1'b1;
                    n_out.element_value = '0;
                    n_out.is_element    = 1'b0;
                    n_out.is_last       = 1'b1;
                    n_out.push_rejected = 1'b0;
                    case (i_in_data.mode) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            if (w_full) begin
                                n_out.push_rejected = 1'b1;
                            end else begin
                                w_wr_en = 1'b1;
                                n_fill  = r_fill + CW'(1);
                                if (i_in_data.mode == MODE_PUSH_FRONT) begin
                                    w_wr_addr = (r_front == '0) ? PW'(DEPTH - 1)
                                                                : r_front - PW'(1);
                                    n_front   = w_wr_addr;
                                end else begin
                                    w_wr_addr = wrap(SW'(r_front) + SW'(r_fill));
                                end
                            end
                        end
                        MODE_DROP_FRONT, MODE_DROP_BACK: begin
                            n_fill = r_fill - w_drop_n;
                            if (i_in_data.mode == MODE_DROP_FRONT) begin
                                n_front = wrap(SW'(r_front) + SW'(w_drop_n));
                            end
                        end
                        MODE_DUMP: begin
                            if (r_fill != '0) begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.fill_level = 7'(n_fill);
                end
            end
            ST_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.element_value = 32'($signed(r_rd_data));
                    n_out.is_element    = 1'b1;
                    n_out.is_last       = w_dump_last;
                    n_out.fill_level    = 7'(r_fill);
                    n_out.push_rejected = 1'b0;
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_out <= n_out;
    end

endmodule
